/* sv/jst_pkg.sv */
// Shared types, codes and keyword tables for the JSON stream tokenizer.
package jst_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'd0,
		MODE_STRING = 4'd1,
		MODE_TRUE   = 4'd2,
		MODE_FALSE  = 4'd3,
		MODE_NULL   = 4'd4,
		MODE_NUMBER = 4'd5
	} lex_mode_t;

	typedef enum logic [1:0] {
		PEND_NONE       = 2'd0,
		PEND_DIGIT      = 2'd1,
		PEND_SIGN_DIGIT = 2'd2
	} pend_t;

	localparam logic [3:0] KIND_LBRACE   = 4'd0;
	localparam logic [3:0] KIND_RBRACE   = 4'd1;
	localparam logic [3:0] KIND_LBRACKET = 4'd2;
	localparam logic [3:0] KIND_RBRACKET = 4'd3;
	localparam logic [3:0] KIND_COLON    = 4'd4;
	localparam logic [3:0] KIND_COMMA    = 4'd5;
	localparam logic [3:0] KIND_STRING   = 4'd6;
	localparam logic [3:0] KIND_TRUE     = 4'd7;
	localparam logic [3:0] KIND_FALSE    = 4'd8;
	localparam logic [3:0] KIND_NULL     = 4'd9;
	localparam logic [3:0] KIND_INTEGER  = 4'd10;
	localparam logic [3:0] KIND_FLOAT    = 4'd11;
	localparam logic [3:0] KIND_END      = 4'd12;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_MALFORMED = 2'd1;
	localparam logic [1:0] STAT_TOO_DEEP  = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG  = 2'd3;

	localparam logic [1:0] FLAG_POINT = 2'b01;
	localparam logic [1:0] FLAG_EXP   = 2'b10;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// expected character of a keyword at a given position
	function automatic logic [7:0] kw_char(input lex_mode_t m, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (m)
			MODE_TRUE: begin
				case (idx)
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			MODE_FALSE: begin
				case (idx)
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			MODE_NULL: begin
				case (idx)
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] kw_len(input lex_mode_t m);
		return (m == MODE_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [3:0] kw_kind(input lex_mode_t m);
		logic [3:0] k;
		case (m)
			MODE_TRUE:  k = KIND_TRUE;
			MODE_FALSE: k = KIND_FALSE;
			default:    k = KIND_NULL;
		endcase
		return k;
	endfunction

endpackage

/* sv/json_stream_tokenizer.sv */
// Streaming JSON tokenizer: one byte per word in, token words out.
// A byte is registered at the input, then lexed from that register into a 4-entry result
// queue, from which its result words are offered in order.
// Throughput: one byte per cycle while the output is not stalled and each byte yields at
// most one word; after a byte that yields two or three words, input stalls until the queue holds at most one word.
// Reset clears the lexer state except the bracket stack, empties the queue and sets max_nesting to 64.
module json_stream_tokenizer #(
	parameter int STACK_DEPTH   = 64,
	parameter int MAX_DOC_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [1:0]  status,
	output logic        last_result
);

	localparam int PW_RAW = $clog2(MAX_DOC_BYTES + 1);
	localparam int PW     = (PW_RAW > 16) ? PW_RAW : 16;
	localparam int LW     = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_DOC_BYTES);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// lexer state
	logic [6:0]             max_nesting_q;
	logic [STACK_DEPTH-1:0] stack_q, stack_n;
	logic [LW-1:0]          level_q, level_n;
	jst_pkg::lex_mode_t     mode_q, mode_n;
	logic [2:0]             prog_q, prog_n;
	logic [1:0]             flags_q, flags_n;
	jst_pkg::pend_t         pend_q, pend_n;
	logic [PW-1:0]          pos_q, pos_n;
	logic [PW-1:0]          tb_q, tb_n;
	logic                   err_q, err_n;
	logic [1:0]             errc_q, errc_n;

	// result queue
	jst_pkg::result_t fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	jst_pkg::result_t res [3];
	logic [1:0] n_res;
	logic       proc;
	logic       pop;

	assign proc     = valid_s1 && (cnt_q <= 3'd1);
	assign in_stall = valid_s1 && !proc;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_comb begin
		logic [7:0]    c;
		logic [PW-1:0] p;
		logic          is_ws, is_dig, do_idle, push, pop_stk, push_bit;
		logic [31:0]   lim;
		logic [2:0]    kl;

		c        = byte_s1;
		p        = pos_q;
		is_ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
		           (c == 8'h0C) || (c == 8'h0D);
		is_dig   = (c >= "0") && (c <= "9");
		do_idle  = 1'b0;
		push     = 1'b0;
		pop_stk  = 1'b0;
		push_bit = (c == "[");
		lim      = (32'(max_nesting_q) > 32'(STACK_DEPTH)) ? 32'(STACK_DEPTH)
		                                                   : 32'(max_nesting_q);
		kl       = jst_pkg::kw_len(mode_q);

		level_n = level_q;
		mode_n  = mode_q;
		prog_n  = prog_q;
		flags_n = flags_q;
		pend_n  = pend_q;
		tb_n    = tb_q;
		err_n   = err_q;
		errc_n  = errc_q;
		n_res   = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res[i] = '0;
		end

		pos_n = (pos_q < MAX_POS) ? pos_q + PW'(1) : pos_q;

		if (!err_q) begin
			if (p >= MAX_POS) begin
				err_n  = 1'b1;
				errc_n = jst_pkg::STAT_TOO_LONG;
			end else if (mode_q == jst_pkg::MODE_STRING) begin
				if (c == 8'h22) begin
					res[n_res] = '{jst_pkg::KIND_STRING, tb_q[15:0],
						16'(p - tb_q), jst_pkg::STAT_OK, 1'b0};
					n_res  = n_res + 2'd1;
					mode_n = jst_pkg::MODE_IDLE;
				end
			end else if (mode_q == jst_pkg::MODE_TRUE || mode_q == jst_pkg::MODE_FALSE ||
			             mode_q == jst_pkg::MODE_NULL) begin
				if (prog_q < kl && c == jst_pkg::kw_char(mode_q, prog_q)) begin
					prog_n = prog_q + 3'd1;
					if (prog_n == kl) begin
						res[n_res] = '{jst_pkg::kw_kind(mode_q), tb_q[15:0],
							16'(kl), jst_pkg::STAT_OK, 1'b0};
						n_res  = n_res + 2'd1;
						mode_n = jst_pkg::MODE_IDLE;
						prog_n = 3'd0;
					end
				end else begin
					err_n  = 1'b1;
					errc_n = jst_pkg::STAT_MALFORMED;
				end
			end else if (mode_q == jst_pkg::MODE_NUMBER) begin
				if (pend_q == jst_pkg::PEND_DIGIT) begin
					if (is_dig) begin
						pend_n = jst_pkg::PEND_NONE;
					end else begin
						err_n  = 1'b1;
						errc_n = jst_pkg::STAT_MALFORMED;
					end
				end else if (pend_q == jst_pkg::PEND_SIGN_DIGIT) begin
					if (is_dig || c == "+" || c == "-") begin
						pend_n = jst_pkg::PEND_NONE;
					end else begin
						err_n  = 1'b1;
						errc_n = jst_pkg::STAT_MALFORMED;
					end
				end else if (is_dig) begin
					mode_n = mode_q;
				end else if (c == "e" && !flags_q[1]) begin
					flags_n = flags_q | jst_pkg::FLAG_EXP;
					pend_n  = jst_pkg::PEND_SIGN_DIGIT;
				end else if (c == "." && flags_q == 2'b00) begin
					flags_n = flags_q | jst_pkg::FLAG_POINT;
					pend_n  = jst_pkg::PEND_DIGIT;
				end else if (c == "," || c == "}" || c == "]" || is_ws) begin
					res[n_res] = '{(flags_q != 2'b00) ? jst_pkg::KIND_FLOAT
					                                  : jst_pkg::KIND_INTEGER,
						tb_q[15:0], 16'(p - tb_q), jst_pkg::STAT_OK, 1'b0};
					n_res   = n_res + 2'd1;
					mode_n  = jst_pkg::MODE_IDLE;
					flags_n = 2'b00;
					do_idle = 1'b1;
				end else begin
					err_n  = 1'b1;
					errc_n = jst_pkg::STAT_MALFORMED;
				end
			end else begin
				do_idle = 1'b1;
			end

			// delimiter bytes and bytes between tokens
			if (do_idle && !is_ws) begin
				if (c == "{" || c == "[") begin
					if (32'(level_q) >= lim) begin
						err_n  = 1'b1;
						errc_n = jst_pkg::STAT_TOO_DEEP;
					end else begin
						push    = 1'b1;
						level_n = level_q + LW'(1);
						res[n_res] = '{(c == "[") ? jst_pkg::KIND_LBRACKET
						                          : jst_pkg::KIND_LBRACE,
							p[15:0], 16'd1, jst_pkg::STAT_OK, 1'b0};
						n_res = n_res + 2'd1;
					end
				end else if (c == "}" || c == "]") begin
					if (level_q != '0 && stack_q[0] == (c == "]")) begin
						pop_stk = 1'b1;
						level_n = level_q - LW'(1);
						res[n_res] = '{(c == "]") ? jst_pkg::KIND_RBRACKET
						                          : jst_pkg::KIND_RBRACE,
							p[15:0], 16'd1, jst_pkg::STAT_OK, 1'b0};
						n_res = n_res + 2'd1;
					end else begin
						err_n  = 1'b1;
						errc_n = jst_pkg::STAT_MALFORMED;
					end
				end else if (c == ":") begin
					res[n_res] = '{jst_pkg::KIND_COLON, p[15:0], 16'd1,
						jst_pkg::STAT_OK, 1'b0};
					n_res = n_res + 2'd1;
				end else if (c == ",") begin
					res[n_res] = '{jst_pkg::KIND_COMMA, p[15:0], 16'd1,
						jst_pkg::STAT_OK, 1'b0};
					n_res = n_res + 2'd1;
				end else if (c == 8'h22) begin
					mode_n = jst_pkg::MODE_STRING;
					tb_n   = p + PW'(1);
				end else if (c == "t" || c == "f" || c == "n") begin
					mode_n = (c == "t") ? jst_pkg::MODE_TRUE :
					         (c == "f") ? jst_pkg::MODE_FALSE : jst_pkg::MODE_NULL;
					prog_n = 3'd1;
					tb_n   = p;
				end else if (is_dig || c == "+" || c == "-" || c == ".") begin
					mode_n  = jst_pkg::MODE_NUMBER;
					tb_n    = p;
					flags_n = (c == ".") ? jst_pkg::FLAG_POINT : 2'b00;
					pend_n  = is_dig ? jst_pkg::PEND_NONE : jst_pkg::PEND_DIGIT;
				end else begin
					err_n  = 1'b1;
					errc_n = jst_pkg::STAT_MALFORMED;
				end
			end
		end

		if (eot_s1) begin
			if (!err_n) begin
				if (mode_n == jst_pkg::MODE_NUMBER) begin
					if (pend_n != jst_pkg::PEND_NONE) begin
						err_n  = 1'b1;
						errc_n = jst_pkg::STAT_MALFORMED;
					end else begin
						res[n_res] = '{(flags_n != 2'b00) ? jst_pkg::KIND_FLOAT
						                                  : jst_pkg::KIND_INTEGER,
							tb_n[15:0], 16'(p + PW'(1) - tb_n), jst_pkg::STAT_OK, 1'b0};
						n_res = n_res + 2'd1;
					end
				end else if (mode_n != jst_pkg::MODE_IDLE) begin
					err_n  = 1'b1;
					errc_n = jst_pkg::STAT_MALFORMED;
				end
				if (!err_n && level_n != '0) begin
					err_n  = 1'b1;
					errc_n = jst_pkg::STAT_MALFORMED;
				end
			end
			res[n_res] = '{jst_pkg::KIND_END, pos_n[15:0], 16'd0,
				err_n ? errc_n : jst_pkg::STAT_OK, 1'b0};
			n_res = n_res + 2'd1;
			// start the next document
			level_n = '0;
			mode_n  = jst_pkg::MODE_IDLE;
			prog_n  = 3'd0;
			flags_n = 2'b00;
			pend_n  = jst_pkg::PEND_NONE;
			pos_n   = '0;
			tb_n    = '0;
			err_n   = 1'b0;
			errc_n  = jst_pkg::STAT_OK;
		end

		if (n_res != 2'd0) begin
			res[n_res - 2'd1].last = 1'b1;
		end

		stack_n = stack_q;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (push) begin
				stack_n[i] = (i == 0) ? push_bit : stack_q[(i == 0) ? 0 : i - 1];
			end else if (pop_stk) begin
				stack_n[i] = (i == STACK_DEPTH - 1) ? stack_q[i]
				                                    : stack_q[(i == STACK_DEPTH - 1) ? i : i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nesting_q <= 7'd64;
		end else if (cfg_wr_en) begin
			max_nesting_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			mode_q  <= jst_pkg::MODE_IDLE;
			prog_q  <= 3'd0;
			flags_q <= 2'b00;
			pend_q  <= jst_pkg::PEND_NONE;
			pos_q   <= '0;
			tb_q    <= '0;
			err_q   <= 1'b0;
			errc_q  <= jst_pkg::STAT_OK;
		end else if (proc) begin
			level_q <= level_n;
			mode_q  <= mode_n;
			prog_q  <= prog_n;
			flags_q <= flags_n;
			pend_q  <= pend_n;
			pos_q   <= pos_n;
			tb_q    <= tb_n;
			err_q   <= err_n;
			errc_q  <= errc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			stack_q <= stack_n;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < n_res) begin
					fifo_q[wr_q + 2'(i)] <= res[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (proc) begin
				wr_q <= wr_q + n_res;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + (proc ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	assign out_valid    = (cnt_q != 3'd0);
	assign token_kind   = fifo_q[rd_q].kind;
	assign token_start  = fifo_q[rd_q].start;
	assign token_length = fifo_q[rd_q].length;
	assign status       = fifo_q[rd_q].status;
	assign last_result  = fifo_q[rd_q].last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overfilled");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		proc |-> (cnt_q <= 3'd1))
		else $error("byte lexed without queue room");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level_q) <= 32'(STACK_DEPTH))
		else $error("nesting level beyond stack depth");
	a_doc_end: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && eot_s1) |=> (level_q == '0 && pos_q == '0 && !err_q))
		else $error("document state not cleared after last byte");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for the JSON stream tokenizer: byte driver, token monitor and predictor.
module tb_top;

	localparam int WDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [1:0]  status;
	logic        last_result;

	json_stream_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .status(status),
		.last_result(last_result)
	);

	// predictor state
	logic               nest_stk [64];
	int unsigned        nest_lvl;
	jst_pkg::lex_mode_t mode;
	int unsigned        kw_pos;
	logic [1:0]         num_flags;
	jst_pkg::pend_t     pend;
	int unsigned        pos;
	int unsigned        tok_begin;
	logic               err_set;
	logic [1:0]         err_code;
	int unsigned        nest_max;

	logic [8:0]       byte_q [$];
	jst_pkg::result_t token_q [$];
	int               errors = 0;
	int               idle_cnt;
	int               in_gap;
	int               out_gap;
	bit               hold_req;
	bit               hold_out;
	int               hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input jst_pkg::result_t got,
			input jst_pkg::result_t exp_r);
		$display("mismatch %s: got k=%0d s=%0d l=%0d st=%0d last=%0d %s%0d %s%0d",
			what, got.kind, got.start, got.length, got.status, got.last,
			"exp k=", exp_r.kind, "", exp_r.start);
		$display("  exp l=%0d st=%0d last=%0d", exp_r.length, exp_r.status, exp_r.last);
		errors++;
	endtask

	function automatic void doc_clear();
		nest_lvl = 0; mode = jst_pkg::MODE_IDLE; kw_pos = 0; num_flags = 2'b00;
		pend = jst_pkg::PEND_NONE; pos = 0; tok_begin = 0; err_set = 1'b0;
		err_code = jst_pkg::STAT_OK;
	endfunction

	function automatic void flag(input logic [1:0] code);
		if (!err_set) begin
			err_set = 1'b1;
			err_code = code;
		end
	endfunction

	function automatic void push_tok(input logic [3:0] k, input int unsigned s,
			input int unsigned l, input logic [1:0] st);
		jst_pkg::result_t r;
		r.kind = k; r.start = s[15:0]; r.length = l[15:0]; r.status = st; r.last = 1'b0;
		token_q.push_back(r);
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] kw_letter(input jst_pkg::lex_mode_t m, input int unsigned i);
		string s;
		s = (m == jst_pkg::MODE_TRUE) ? "true" : (m == jst_pkg::MODE_FALSE) ? "false" : "null";
		return s[i];
	endfunction

	function automatic void lex_between(input logic [7:0] c, input int unsigned p);
		int unsigned lim;
		logic want;
		lim = nest_max > 64 ? 64 : nest_max;
		if (is_space(c)) return;
		if (c == "{" || c == "[") begin
			if (nest_lvl >= lim) begin
				flag(jst_pkg::STAT_TOO_DEEP);
				return;
			end
			nest_stk[nest_lvl] = (c == "[");
			nest_lvl++;
			push_tok(c == "[" ? jst_pkg::KIND_LBRACKET : jst_pkg::KIND_LBRACE, p, 1,
				jst_pkg::STAT_OK);
		end else if (c == "}" || c == "]") begin
			want = (c == "]");
			if (nest_lvl > 0 && nest_stk[nest_lvl-1] == want) begin
				nest_lvl--;
				push_tok(c == "]" ? jst_pkg::KIND_RBRACKET : jst_pkg::KIND_RBRACE, p, 1,
					jst_pkg::STAT_OK);
			end else flag(jst_pkg::STAT_MALFORMED);
		end else if (c == ":") push_tok(jst_pkg::KIND_COLON, p, 1, jst_pkg::STAT_OK);
		else if (c == ",") push_tok(jst_pkg::KIND_COMMA, p, 1, jst_pkg::STAT_OK);
		else if (c == "\"") begin
			mode = jst_pkg::MODE_STRING;
			tok_begin = p + 1;
		end else if (c == "t" || c == "f" || c == "n") begin
			mode = c == "t" ? jst_pkg::MODE_TRUE :
			       c == "f" ? jst_pkg::MODE_FALSE : jst_pkg::MODE_NULL;
			kw_pos = 1;
			tok_begin = p;
		end else if (is_num(c) || c == "+" || c == "-" || c == ".") begin
			mode = jst_pkg::MODE_NUMBER;
			tok_begin = p;
			num_flags = (c == ".") ? jst_pkg::FLAG_POINT : 2'b00;
			pend = is_num(c) ? jst_pkg::PEND_NONE : jst_pkg::PEND_DIGIT;
		end else flag(jst_pkg::STAT_MALFORMED);
	endfunction

	function automatic void lex_number(input logic [7:0] c, input int unsigned p);
		if (pend == jst_pkg::PEND_DIGIT) begin
			if (is_num(c)) pend = jst_pkg::PEND_NONE; else flag(jst_pkg::STAT_MALFORMED);
			return;
		end
		if (pend == jst_pkg::PEND_SIGN_DIGIT) begin
			if (is_num(c) || c == "+" || c == "-") pend = jst_pkg::PEND_NONE;
			else flag(jst_pkg::STAT_MALFORMED);
			return;
		end
		if (is_num(c)) return;
		if (c == "e" && !num_flags[1]) begin
			num_flags |= jst_pkg::FLAG_EXP;
			pend = jst_pkg::PEND_SIGN_DIGIT;
		end else if (c == "." && num_flags == 2'b00) begin
			num_flags |= jst_pkg::FLAG_POINT;
			pend = jst_pkg::PEND_DIGIT;
		end else if (c == "," || c == "}" || c == "]" || is_space(c)) begin
			push_tok(num_flags != 0 ? jst_pkg::KIND_FLOAT : jst_pkg::KIND_INTEGER,
				tok_begin, p - tok_begin, jst_pkg::STAT_OK);
			mode = jst_pkg::MODE_IDLE;
			num_flags = 2'b00;
			lex_between(c, p);
		end else flag(jst_pkg::STAT_MALFORMED);
	endfunction

	function automatic void predict_byte(input logic [7:0] c, input logic eot);
		int unsigned p;
		int n_old;
		int unsigned klen;
		n_old = token_q.size();
		p = pos;
		if (pos < 65536) pos++;
		if (!err_set) begin
			if (p >= 65536) flag(jst_pkg::STAT_TOO_LONG);
			else if (mode == jst_pkg::MODE_STRING) begin
				if (c == "\"") begin
					push_tok(jst_pkg::KIND_STRING, tok_begin, p - tok_begin, jst_pkg::STAT_OK);
					mode = jst_pkg::MODE_IDLE;
				end
			end else if (mode == jst_pkg::MODE_TRUE || mode == jst_pkg::MODE_FALSE ||
			             mode == jst_pkg::MODE_NULL) begin
				klen = (mode == jst_pkg::MODE_FALSE) ? 5 : 4;
				if (kw_pos < klen && c == kw_letter(mode, kw_pos)) begin
					kw_pos++;
					if (kw_pos == klen) begin
						push_tok(mode == jst_pkg::MODE_TRUE ? jst_pkg::KIND_TRUE :
							mode == jst_pkg::MODE_FALSE ? jst_pkg::KIND_FALSE :
							jst_pkg::KIND_NULL, tok_begin, klen, jst_pkg::STAT_OK);
						mode = jst_pkg::MODE_IDLE;
						kw_pos = 0;
					end
				end else flag(jst_pkg::STAT_MALFORMED);
			end else if (mode == jst_pkg::MODE_NUMBER) lex_number(c, p);
			else lex_between(c, p);
		end
		if (eot) begin
			if (!err_set) begin
				if (mode == jst_pkg::MODE_NUMBER) begin
					if (pend != jst_pkg::PEND_NONE) flag(jst_pkg::STAT_MALFORMED);
					else push_tok(num_flags != 0 ? jst_pkg::KIND_FLOAT : jst_pkg::KIND_INTEGER,
						tok_begin, p + 1 - tok_begin, jst_pkg::STAT_OK);
				end else if (mode != jst_pkg::MODE_IDLE) flag(jst_pkg::STAT_MALFORMED);
				if (nest_lvl != 0) flag(jst_pkg::STAT_MALFORMED);
			end
			push_tok(jst_pkg::KIND_END, pos, 0, err_set ? err_code : jst_pkg::STAT_OK);
			doc_clear();
		end
		if (token_q.size() > n_old) token_q[token_q.size()-1].last = 1'b1;
	endfunction

	// stimulus helpers
	task automatic add_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back({close && i == s.len() - 1, s[i]});
	endtask

	function automatic string rand_value(input int depth);
		string s;
		int n;
		case ($urandom_range(0, 7))
			0: s = "true";
			1: s = "false";
			2: s = "null";
			3: s = $sformatf("\"%0d\"", $urandom_range(0, 999));
			4: s = $sformatf("%0d", $urandom_range(0, 99999));
			5: s = $sformatf("-%0d.%0de+%0d", $urandom_range(0, 99), $urandom_range(0, 9),
				$urandom_range(0, 9));
			default: begin
				if (depth > 3) s = "0";
				else if ($urandom_range(0, 1)) begin
					s = "[";
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) s = {s, i ? ", " : "", rand_value(depth + 1)};
					s = {s, "]"};
				end else begin
					s = "{";
					n = $urandom_range(0, 2);
					for (int i = 0; i < n; i++)
						s = {s, i ? "," : "", "\"k\":", rand_value(depth + 1)};
					s = {s, "}"};
				end
			end
		endcase
		return s;
	endfunction

	task automatic run_phase(input logic [6:0] limit);
		while (byte_q.size() != 0 || token_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		nest_max = limit;
	endtask

	task automatic random_docs(input int budget);
		string s;
		int sent;
		logic [8:0] w;
		sent = 0;
		while (sent < budget) begin
			s = rand_value(0);
			if ($urandom_range(0, 4) == 0) begin
				// corrupt one byte
				w = 9'($urandom_range(0, 255));
				s[$urandom_range(0, s.len() - 1)] = w[7:0];
			end
			if ($urandom_range(0, 3) == 0) s = {" ", s, "\t"};
			add_text(s, 1'b1);
			sent += s.len();
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			end_of_text <= 1'b0;
			in_gap <= 0;
			doc_clear();
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				predict_byte(data_byte, end_of_text);
				void'(byte_q.pop_front());
			end
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (byte_q.size() > 0) begin
				in_valid <= 1'b1;
				{end_of_text, data_byte} <= byte_q[0];
				in_gap <= ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 9)) : 0;
			end else in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		jst_pkg::result_t got;
		jst_pkg::result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
			idle_cnt <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{token_kind, token_start, token_length, status, last_result};
				if (token_q.size() == 0) report("unexpected", got, got);
				else begin
					exp_r = token_q.pop_front();
					if (got != exp_r) report("token", got, exp_r);
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (hold_out) out_stall <= 1'b1;
			else if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap <= out_gap - 1;
			end else begin
				out_stall <= 1'b0;
				if (out_valid && !out_stall)
					out_gap <= ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 9)) : 0;
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_out <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_req && hold_cnt < 60) begin
			hold_out <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			hold_out <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [8:0] w;
		hold_req = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 7'd0;
		nest_max = 64;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed documents
		add_text("{\"a\":[true,false,null,-1.5e+3,.5,7]}", 1'b1);
		add_text("12", 1'b1);
		add_text("1e", 1'b1);
		add_text("[}", 1'b1);
		add_text("\"abc", 1'b1);
		add_text("tru", 1'b1);
		add_text("1.2.3 ", 1'b1);
		add_text("[[", 1'b1);
		add_text("]", 1'b1);
		byte_q.push_back({1'b1, 8'hff});
		byte_q.push_back({1'b1, 8'h00});
		add_text("\v5\f\r", 1'b1);
		// long hold-off while bytes pile up
		add_text("[1,2,3,4,5,6,7,8,9,0,1,2,3]", 1'b1);
		hold_req = 1'b1;
		run_phase(7'd1);
		add_text("[[1]]", 1'b1);
		add_text("{}", 1'b1);
		run_phase(7'd0);
		add_text("[]", 1'b1);
		random_docs(25);
		run_phase(7'd127);
		random_docs(45);
		run_phase(7'd3);
		random_docs(25);
		// raw random bytes of any value, with random end-of-text marks
		for (int i = 0; i < 40; i++) begin
			w = 9'($urandom_range(0, 511));
			w[8] = ($urandom_range(0, 7) == 0);
			byte_q.push_back(w);
		end
		byte_q.push_back({1'b1, 8'h20});
		run_phase(7'd64);
		if (errors == 0 && token_q.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
